// ===== rtl/tmn_pkg.sv =====
// Shared types, codes and defaults of the token mutual exclusion node.
package tmn_pkg;

	localparam int unsigned NODES_DEF      = 8;
	localparam int unsigned CLOCK_BITS_DEF = 32;
	localparam int unsigned ADDR_W         = 3;

	// Register index as decoded from paddr[2].
	localparam logic REG_NODE_ID = 1'b0;
	localparam logic REG_HOLD    = 1'b1;

	typedef enum logic [2:0] {
		K_LOCAL   = 3'd0,
		K_RELEASE = 3'd1,
		K_REMOTE  = 3'd2,
		K_TOKEN   = 3'd3,
		K_FAIL    = 3'd4,
		K_RECOVER = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ACT_STATUS = 2'd0,
		ACT_BCAST  = 2'd1,
		ACT_TOKEN  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_REQ  = 2'd1,
		PH_CS   = 2'd2,
		PH_FAIL = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RMW,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SEND_RD,
		ST_SEND_OUT,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  peer;
		logic [31:0] msg_clock;
		logic [2:0]  word_index;
		logic [31:0] word_value;
		logic        word_last;
	} in_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  target;
		logic [31:0] out_clock;
		logic [2:0]  out_index;
		logic [31:0] out_value;
		logic        out_last;
		logic [1:0]  node_state;
	} out_t;

	// Commands from the sequencer to the table memories.
	typedef struct packed {
		logic rd;
		logic req_we;
		logic srv_we;
	} tbl_cmd_t;

endpackage

// ===== rtl/token_mutex_node.sv =====
// Top level of the token mutual exclusion node: register port, result register, core.
//
// One node of token-based mutual exclusion with Lamport clocks. Each input
// transaction is an event (local request, release, remote request, token word,
// fail or recover) and produces one status or broadcast result, or a stream of
// NODES token words when the token is handed on. Items are handled one at a
// time through a single read port on the two tables: local request, fail,
// recover and token words pass from acceptance through an emit state to
// the result register; a remote request first passes a read-modify-write
// state, then the emit state or, when it draws the token away, the token
// stream; a release examines up to NODES-1 peers in turn, each with a read
// state and a compare state, then gives its status result or the token
// stream, in which each word has a read state and an output state. A new
// transaction is accepted as soon as the previous one's last result has
// been written into the result register, even while that result still
// waits to be taken. Tables come out of reset cleared by per-entry valid
// bits, so there is no clearing pass. Clocks saturate at their all-ones value.
module token_mutex_node #(
	parameter int unsigned NODES      = tmn_pkg::NODES_DEF,
	parameter int unsigned CLOCK_BITS = tmn_pkg::CLOCK_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  tmn_pkg::in_t               item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output tmn_pkg::out_t              result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tmn_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import tmn_pkg::*;

	localparam int unsigned AW = $clog2(NODES);

	logic [2:0]            node_id_q;
	logic                  hold_q;
	logic [AW-1:0]         me_q;
	logic                  cfg_wr;
	logic                  grant_token;
	out_t                  res_q;
	logic                  res_valid_q;
	logic                  res_free;
	logic                  res_push;
	out_t                  res_s;
	tbl_cmd_t              cmd;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [CLOCK_BITS-1:0] wr_data;
	logic [CLOCK_BITS-1:0] req_rd;
	logic [CLOCK_BITS-1:0] srv_rd;

	// The node index is taken modulo NODES by repeated subtraction; the
	// value has only three bits, so a handful of steps suffice.
	function automatic logic [AW-1:0] id_mod(input logic [2:0] id);
		logic [6:0] v;
		v = {4'b0, id};
		for (int k = 0; k < 8; k++) begin
			if (32'(v) >= NODES) begin
				v = v - 7'(NODES);
			end
		end
		return AW'(v);
	endfunction

	// Register port: pready is always high, so a write lands at the access
	// cycle. Only paddr[2] is decoded.
	assign pready      = 1'b1;
	assign cfg_wr      = psel && penable && pwrite && pready;
	assign grant_token = cfg_wr && (paddr[2] == REG_HOLD) && pwdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
			hold_q    <= 1'b0;
			me_q      <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_NODE_ID) begin
				node_id_q <= pwdata[2:0];
				me_q      <= id_mod(pwdata[2:0]);
			end else begin
				hold_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		case (paddr[2])
			REG_NODE_ID: prdata = {29'b0, node_id_q};
			REG_HOLD:    prdata = {31'b0, hold_q};
			default:     prdata = '0;
		endcase
	end

	// Result register: it parts the core from the output handshake, so the
	// core can move on while a finished result waits to be taken.
	assign res_free     = !res_valid_q || result_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_push) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q <= res_s;
		end
	end

	tmn_seq #(
		.NODES      (NODES),
		.CLOCK_BITS (CLOCK_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.me          (me_q),
		.grant_token (grant_token),
		.res_free    (res_free),
		.res_push    (res_push),
		.res         (res_s),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.req_rd      (req_rd),
		.srv_rd      (srv_rd)
	);

	// Granting the token by configuration also empties the served table.
	tmn_tables #(
		.NODES      (NODES),
		.CLOCK_BITS (CLOCK_BITS)
	) u_tables (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.clear_srv (grant_token),
		.req_rd    (req_rd),
		.srv_rd    (srv_rd)
	);

endmodule

// ===== rtl/tmn_tables.sv =====
// Request-clock and token last-served memories with per-entry valid bits.
module tmn_tables #(
	parameter int unsigned NODES      = tmn_pkg::NODES_DEF,
	parameter int unsigned CLOCK_BITS = tmn_pkg::CLOCK_BITS_DEF,
	localparam int unsigned AW        = $clog2(NODES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmn_pkg::tbl_cmd_t     cmd,
	input  logic [AW-1:0]         rd_addr,
	input  logic [AW-1:0]         wr_addr,
	input  logic [CLOCK_BITS-1:0] wr_data,
	input  logic                  clear_srv,
	output logic [CLOCK_BITS-1:0] req_rd,
	output logic [CLOCK_BITS-1:0] srv_rd
);
	import tmn_pkg::*;

	logic [CLOCK_BITS-1:0] req_mem [NODES];
	logic [CLOCK_BITS-1:0] srv_mem [NODES];
	logic [CLOCK_BITS-1:0] req_dat_q;
	logic [CLOCK_BITS-1:0] srv_dat_q;
	logic [NODES-1:0]      req_vld_q;
	logic [NODES-1:0]      srv_vld_q;
	logic                  req_vrd_q;
	logic                  srv_vrd_q;

	always_ff @(posedge clk) begin
		if (cmd.req_we) begin
			req_mem[wr_addr] <= wr_data;
		end
		if (cmd.srv_we) begin
			srv_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			req_dat_q <= req_mem[rd_addr];
			srv_dat_q <= srv_mem[rd_addr];
		end
	end

	// An entry never written since reset (or since the token was granted
	// by configuration, for the served table) reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_q <= '0;
			srv_vld_q <= '0;
			req_vrd_q <= 1'b0;
			srv_vrd_q <= 1'b0;
		end else begin
			if (clear_srv) begin
				srv_vld_q <= '0;
			end else if (cmd.srv_we) begin
				srv_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.req_we) begin
				req_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd) begin
				req_vrd_q <= req_vld_q[rd_addr];
				srv_vrd_q <= srv_vld_q[rd_addr];
			end
		end
	end

	assign req_rd = req_vrd_q ? req_dat_q : '0;
	assign srv_rd = srv_vrd_q ? srv_dat_q : '0;

endmodule

// ===== rtl/tmn_seq.sv =====
// Sequencer: node state, Lamport clock and the read-modify-write control.
module tmn_seq #(
	parameter int unsigned NODES      = tmn_pkg::NODES_DEF,
	parameter int unsigned CLOCK_BITS = tmn_pkg::CLOCK_BITS_DEF,
	localparam int unsigned AW        = $clog2(NODES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  tmn_pkg::in_t          item,
	input  logic [AW-1:0]         me,
	input  logic                  grant_token,
	input  logic                  res_free,
	output logic                  res_push,
	output tmn_pkg::out_t         res,
	output tmn_pkg::tbl_cmd_t     cmd,
	output logic [AW-1:0]         rd_addr,
	output logic [AW-1:0]         wr_addr,
	output logic [CLOCK_BITS-1:0] wr_data,
	input  logic [CLOCK_BITS-1:0] req_rd,
	input  logic [CLOCK_BITS-1:0] srv_rd
);
	import tmn_pkg::*;

	localparam logic [63:0] CLK_MAX64 = (CLOCK_BITS >= 64) ? '1 :
		((64'd1 << CLOCK_BITS) - 64'd1);
	localparam logic [AW-1:0] LAST_IDX = AW'(NODES - 1);

	seq_state_t            state_q, state_d;
	logic [CLOCK_BITS-1:0] lamport_q, lamport_d;
	logic                  token_q, token_d;
	phase_t                phase_q, phase_d;
	logic                  failed_q, failed_d;
	action_t               act_q, act_d;
	logic [CLOCK_BITS-1:0] mclk_q, mclk_d;
	logic [AW-1:0]         tgt_q, tgt_d;
	logic [AW-1:0]         idx_q, idx_d;
	logic [AW-1:0]         cnt_q, cnt_d;
	logic [AW-1:0]         j_q, j_d;

	logic [CLOCK_BITS-1:0] mclk_in;
	logic [CLOCK_BITS-1:0] wval_in;
	logic [CLOCK_BITS-1:0] lam_inc;
	logic [CLOCK_BITS-1:0] lam_up;
	logic                  peer_ok;
	logic                  widx_ok;
	logic                  pending;

	function automatic logic [CLOCK_BITS-1:0] sat_in(input logic [31:0] v);
		logic [63:0] w;
		w = {32'b0, v};
		if (w > CLK_MAX64) begin
			return '1;
		end
		return w[CLOCK_BITS-1:0];
	endfunction

	function automatic logic [CLOCK_BITS-1:0] inc_sat(input logic [CLOCK_BITS-1:0] v);
		return (v == '1) ? v : v + CLOCK_BITS'(1);
	endfunction

	function automatic logic [AW-1:0] next_peer(input logic [AW-1:0] v);
		return (v == LAST_IDX) ? '0 : v + AW'(1);
	endfunction

	assign mclk_in = sat_in(item.msg_clock);
	assign wval_in = sat_in(item.word_value);
	assign lam_inc = inc_sat(lamport_q);
	assign lam_up  = inc_sat((mclk_in > lamport_q) ? mclk_in : lamport_q);
	assign peer_ok = (32'(item.peer) < NODES) && (32'(item.peer) != 32'(me));
	assign widx_ok = 32'(item.word_index) < NODES;
	// The raised request clock exceeds the served clock if either operand does.
	assign pending = (mclk_q > srv_rd) || (req_rd > srv_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			lamport_q <= '0;
			token_q   <= 1'b0;
			phase_q   <= PH_IDLE;
			failed_q  <= 1'b0;
			act_q     <= ACT_STATUS;
			tgt_q     <= '0;
			idx_q     <= '0;
			cnt_q     <= '0;
			j_q       <= '0;
		end else begin
			state_q   <= state_d;
			lamport_q <= lamport_d;
			token_q   <= grant_token ? 1'b1 : token_d;
			phase_q   <= phase_d;
			failed_q  <= failed_d;
			act_q     <= act_d;
			tgt_q     <= tgt_d;
			idx_q     <= idx_d;
			cnt_q     <= cnt_d;
			j_q       <= j_d;
		end
	end

	always_ff @(posedge clk) begin
		mclk_q <= mclk_d;
	end

	always_comb begin
		state_d    = state_q;
		lamport_d  = lamport_q;
		token_d    = token_q;
		phase_d    = phase_q;
		failed_d   = failed_q;
		act_d      = act_q;
		mclk_d     = mclk_q;
		tgt_d      = tgt_q;
		idx_d      = idx_q;
		cnt_d      = cnt_q;
		j_d        = j_q;
		cmd        = '0;
		rd_addr    = '0;
		wr_addr    = '0;
		wr_data    = '0;
		res_push   = 1'b0;
		res        = '0;
		item_ready = (state_q == ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					act_d   = ACT_STATUS;
					state_d = ST_EMIT;
					case (item.kind)
						K_FAIL: begin
							failed_d = 1'b1;
							phase_d  = PH_FAIL;
						end
						K_RECOVER: begin
							if (failed_q) begin
								failed_d = 1'b0;
								phase_d  = PH_IDLE;
							end
						end
						K_LOCAL: begin
							if (!failed_q && phase_q == PH_IDLE) begin
								lamport_d  = lam_inc;
								cmd.req_we = 1'b1;
								wr_addr    = me;
								wr_data    = lam_inc;
								phase_d    = token_q ? PH_CS : PH_REQ;
								act_d      = ACT_BCAST;
							end
						end
						K_RELEASE: begin
							if (!failed_q && phase_q == PH_CS) begin
								lamport_d  = lam_inc;
								cmd.srv_we = 1'b1;
								wr_addr    = me;
								wr_data    = lam_inc;
								phase_d    = PH_IDLE;
								j_d        = next_peer(me);
								cnt_d      = AW'(1);
								state_d    = ST_SCAN_RD;
							end
						end
						K_REMOTE: begin
							if (!failed_q) begin
								lamport_d = lam_up;
								mclk_d    = mclk_in;
								if (peer_ok) begin
									tgt_d   = AW'(item.peer);
									cmd.rd  = 1'b1;
									rd_addr = AW'(item.peer);
									state_d = ST_RMW;
								end
							end
						end
						K_TOKEN: begin
							if (!failed_q && !token_q) begin
								if (widx_ok) begin
									cmd.srv_we = 1'b1;
									wr_addr    = AW'(item.word_index);
									wr_data    = wval_in;
								end
								if (item.word_last) begin
									lamport_d = lam_up;
									token_d   = 1'b1;
									if (phase_q == PH_REQ) begin
										phase_d = PH_CS;
									end
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_RMW: begin
				if (mclk_q > req_rd) begin
					cmd.req_we = 1'b1;
					wr_addr    = tgt_q;
					wr_data    = mclk_q;
				end
				if (token_q && phase_q != PH_CS && pending) begin
					token_d = 1'b0;
					phase_d = PH_IDLE;
					idx_d   = '0;
					state_d = ST_SEND_RD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SCAN_RD: begin
				cmd.rd  = 1'b1;
				rd_addr = j_q;
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				if (req_rd > srv_rd) begin
					tgt_d   = j_q;
					token_d = 1'b0;
					idx_d   = '0;
					state_d = ST_SEND_RD;
				end else if (cnt_q == LAST_IDX) begin
					state_d = ST_EMIT;
				end else begin
					cnt_d   = cnt_q + AW'(1);
					j_d     = next_peer(j_q);
					state_d = ST_SCAN_RD;
				end
			end
			ST_SEND_RD: begin
				cmd.rd  = 1'b1;
				rd_addr = idx_q;
				state_d = ST_SEND_OUT;
			end
			ST_SEND_OUT: begin
				if (res_free) begin
					res_push       = 1'b1;
					res.action     = ACT_TOKEN;
					res.target     = 3'(tgt_q);
					res.out_clock  = 32'(lamport_q);
					res.out_index  = 3'(idx_q);
					res.out_value  = 32'(srv_rd);
					res.out_last   = (idx_q == LAST_IDX);
					res.node_state = phase_q;
					if (idx_q == LAST_IDX) begin
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_q + AW'(1);
						state_d = ST_SEND_RD;
					end
				end
			end
			ST_EMIT: begin
				if (res_free) begin
					res_push       = 1'b1;
					res.action     = act_q;
					res.out_clock  = 32'(lamport_q);
					res.out_last   = 1'b1;
					res.node_state = phase_q;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
